// ===== hdl/hacr_pkg.sv =====
// Shared types and constants for the HDMI audio clock regeneration N/CTS selector.
// Holds the N/CTS ROM, field widths, configuration indexes and inter-module structs.
// No dependencies.
package hacr_pkg;

  localparam int RATE_W     = 18;
  localparam int CLK_W      = 20;
  localparam int N_W        = 20;
  localparam int CTS_W      = 32;
  localparam int TOL_W      = 16;
  localparam int NDIV_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_TOL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_N = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_N_DIVISOR  = 2'd2;

  localparam logic [TOL_W-1:0]  RST_CLOCK_TOL  = 16'd100;
  localparam logic [N_W-1:0]    RST_FALLBACK_N = 20'd6144;
  localparam logic [NDIV_W-1:0] RST_N_DIVISOR  = 16'd128;

  // rate / 1000 as (rate * RATE_RECIP) >> RATE_SHIFT, exact for every 18-bit rate
  localparam int RECIP_W    = 19;
  localparam int RATE_SHIFT = 28;
  localparam int RATE_Q_W   = 9;
  localparam int RATE_PROD_W = RATE_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RATE_RECIP = 19'd268436;

  localparam int ROM_SIZE = 45;
  localparam int ROM_CTS_W = 20;

  localparam logic [RATE_W-1:0] ROM_RATE [ROM_SIZE] = '{
    32000, 32000, 32000, 32000, 32000, 32000, 32000, 32000,
    32000, 32000, 32000, 32000, 32000, 32000, 32000,
    44100, 44100, 44100, 44100, 44100, 44100, 44100, 44100,
    44100, 44100, 44100, 44100, 44100, 44100, 44100,
    48000, 48000, 48000, 48000, 48000, 48000, 48000, 48000,
    48000, 48000, 48000, 48000, 48000, 48000, 48000
  };

  localparam logic [CLK_W-1:0] ROM_CLK [ROM_SIZE] = '{
    25174, 25200, 27000, 27027, 54000, 54054, 74175, 74250,
    148351, 148500, 296703, 297000, 593406, 594000, 0,
    25174, 25200, 27000, 27027, 54000, 54054, 74175, 74250,
    148351, 148500, 296703, 297000, 593406, 594000, 0,
    25174, 25200, 27000, 27027, 54000, 54054, 74175, 74250,
    148351, 148500, 296703, 297000, 593406, 594000, 0
  };

  localparam logic [N_W-1:0] ROM_N [ROM_SIZE] = '{
    4576, 4096, 4096, 4096, 4096, 4096, 11648, 4096,
    11648, 4096, 5824, 3072, 5824, 3072, 4096,
    7007, 6272, 6272, 6272, 6272, 6272, 17836, 6272,
    8918, 6272, 4459, 4704, 8918, 9408, 6272,
    6864, 6144, 6144, 6144, 6144, 6144, 11648, 6144,
    5824, 6144, 5824, 5120, 5824, 6144, 6144
  };

  localparam logic [ROM_CTS_W-1:0] ROM_CTS [ROM_SIZE] = '{
    28125, 25200, 27000, 27027, 54000, 54054, 210937, 74250,
    421875, 148500, 421875, 222750, 843750, 445500, 0,
    31250, 28000, 30000, 30030, 60000, 60060, 234375, 82500,
    234375, 165000, 234375, 247500, 937500, 990000, 0,
    28125, 25200, 27000, 27027, 54000, 54054, 140625, 74250,
    140625, 148500, 281250, 247500, 562500, 594000, 0
  };

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef struct packed {
    logic [TOL_W-1:0]  clock_tol;
    logic [N_W-1:0]    fallback_n;
    logic [NDIV_W-1:0] n_divisor;
  } hacr_cfg_t;

  // Classified query handed from front to back
  typedef struct packed {
    logic [N_W-1:0]      n;
    logic [CLK_W-1:0]    clock;
    logic [RATE_Q_W-1:0] rate_q;
    logic [CTS_W-1:0]    cts_base;
    logic                hit;
    logic                use_formula;
  } hacr_job_t;

  // What survives past the clock multiply
  typedef struct packed {
    logic [N_W-1:0]   n;
    logic [CTS_W-1:0] cts_base;
    logic             hit;
    logic             use_formula;
  } hacr_res_t;

endpackage

// ===== hdl/hacr_if.sv =====
// Valid/ready channel interfaces for query and result beats.
// Depends on hacr_pkg for field widths.
interface hacr_in_if;
  logic                         valid;
  logic                         ready;
  logic [hacr_pkg::RATE_W-1:0]  sample_rate_hz;
  logic [hacr_pkg::CLK_W-1:0]   tmds_clock_khz;

  modport source(output valid, output sample_rate_hz, output tmds_clock_khz, input ready);
  modport sink(input valid, input sample_rate_hz, input tmds_clock_khz, output ready);
endinterface

interface hacr_out_if;
  logic                        valid;
  logic                        ready;
  logic [hacr_pkg::N_W-1:0]    n_value;
  logic [hacr_pkg::CTS_W-1:0]  cts_value;
  logic                        table_hit;

  modport source(output valid, output n_value, output cts_value, output table_hit, input ready);
  modport sink(input valid, input n_value, input cts_value, input table_hit, output ready);
endinterface

// ===== hdl/hacr_front.sv =====
// Front end: accepts queries, matches them against the N/CTS ROM and classifies them.
// Depends on hacr_pkg.
module hacr_front #(
  parameter int TABLE_ENTRIES = 45
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hacr_pkg::hacr_cfg_t           cfg,
  input  logic                          in_vld,
  input  logic [hacr_pkg::RATE_W-1:0]   in_rate,
  input  logic [hacr_pkg::CLK_W-1:0]    in_clock,
  output logic                          in_rdy,
  output logic                          job_vld,
  output hacr_pkg::hacr_job_t           job,
  input  logic                          job_rdy
);

  localparam int SCAN = (TABLE_ENTRIES < hacr_pkg::ROM_SIZE) ? TABLE_ENTRIES
                                                             : hacr_pkg::ROM_SIZE;

  logic                              f1_vld_r;
  logic [SCAN-1:0]                   f1_match_r;
  logic [hacr_pkg::CLK_W-1:0]        f1_clock_r;
  logic [hacr_pkg::RATE_Q_W-1:0]     f1_q_r;

  logic [SCAN-1:0]                   match_nxt;
  logic [hacr_pkg::RATE_PROD_W-1:0]  rate_prod;
  logic [hacr_pkg::CLK_W:0]          win_hi;
  logic [hacr_pkg::CLK_W-1:0]        win_lo;
  logic                              tol_ok;
  logic                              advance;

  logic                              hit;
  logic [hacr_pkg::N_W-1:0]          sel_n;
  logic [hacr_pkg::CTS_W-1:0]        sel_cts;

  assign advance = !f1_vld_r || job_rdy;
  assign in_rdy  = advance;

  assign rate_prod = hacr_pkg::RATE_PROD_W'(in_rate) *
                     hacr_pkg::RATE_PROD_W'(hacr_pkg::RATE_RECIP);

  // Lower window bound wraps when the clock is below the tolerance: no window match then
  assign tol_ok = in_clock >= hacr_pkg::CLK_W'(cfg.clock_tol);
  assign win_lo = in_clock - hacr_pkg::CLK_W'(cfg.clock_tol);
  assign win_hi = {1'b0, in_clock} + (hacr_pkg::CLK_W + 1)'(cfg.clock_tol);

  always_comb begin
    for (int i = 0; i < SCAN; i++) begin
      match_nxt[i] = (in_rate == hacr_pkg::ROM_RATE[i]) &&
                     ((hacr_pkg::ROM_CLK[i] == in_clock) ||
                      (tol_ok && (hacr_pkg::ROM_CLK[i] >= win_lo) &&
                       ({1'b0, hacr_pkg::ROM_CLK[i]} <= win_hi)) ||
                      (hacr_pkg::ROM_CLK[i] == '0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else if (advance) begin
      f1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld) begin
      f1_match_r <= match_nxt;
      f1_clock_r <= in_clock;
      f1_q_r     <= rate_prod[hacr_pkg::RATE_SHIFT +: hacr_pkg::RATE_Q_W];
    end
  end

  // First matching entry in table order wins
  always_comb begin
    hit     = 1'b0;
    sel_n   = cfg.fallback_n;
    sel_cts = '1;
    for (int i = SCAN - 1; i >= 0; i--) begin
      if (f1_match_r[i]) begin
        hit     = 1'b1;
        sel_n   = hacr_pkg::ROM_N[i];
        sel_cts = hacr_pkg::CTS_W'(hacr_pkg::ROM_CTS[i]);
      end
    end
  end

  assign job_vld          = f1_vld_r;
  assign job.n            = sel_n;
  assign job.clock        = f1_clock_r;
  assign job.rate_q       = f1_q_r;
  assign job.cts_base     = sel_cts;
  assign job.hit          = hit;
  assign job.use_formula  = (f1_q_r != '0) && (!hit || (sel_cts == '0));

endmodule

// ===== hdl/hacr_fifo.sv =====
// Short queue of classified jobs between front and back.
// Depends on hacr_pkg.
module hacr_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_vld,
  input  hacr_pkg::hacr_job_t  push_job,
  output logic                 push_rdy,
  output logic                 pop_vld,
  output hacr_pkg::hacr_job_t  pop_job,
  input  logic                 pop_rdy
);

  hacr_pkg::hacr_job_t               mem_r [hacr_pkg::FIFO_DEPTH];
  logic [hacr_pkg::FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [hacr_pkg::FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [hacr_pkg::FIFO_CNT_W-1:0]   count_r;
  logic                              push;
  logic                              pop;

  assign push_rdy = count_r != hacr_pkg::FIFO_CNT_W'(hacr_pkg::FIFO_DEPTH);
  assign pop_vld  = count_r != '0;
  assign push     = push_vld && push_rdy;
  assign pop      = pop_vld && pop_rdy;
  assign pop_job  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== hdl/hacr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a sideband carried along.
// No package dependency.
module hacr_div #(
  parameter int DIVIDEND_W = 32,
  parameter int DIVISOR_W  = 16,
  parameter int SIDE_W     = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [DIVIDEND_W-1:0] in_dividend,
  input  logic [DIVISOR_W-1:0]  in_divisor,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_vld,
  output logic [DIVIDEND_W-1:0] out_quot,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int STAGES = DIVIDEND_W;

  logic                  vld_r  [STAGES];
  logic [DIVIDEND_W-1:0] quo_r  [STAGES];
  logic [SIDE_W-1:0]     side_r [STAGES];
  logic [DIVIDEND_W-1:0] dvd_r  [STAGES-1];
  logic [DIVISOR_W-1:0]  dvs_r  [STAGES-1];
  logic [DIVISOR_W-1:0]  rem_r  [STAGES-1];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic                  src_vld;
    logic [DIVIDEND_W-1:0] src_dvd;
    logic [DIVISOR_W-1:0]  src_dvs;
    logic [DIVISOR_W-1:0]  src_rem;
    logic [DIVIDEND_W-1:0] src_quo;
    logic [SIDE_W-1:0]     src_side;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    if (k == 0) begin : g_first
      assign src_vld  = in_vld;
      assign src_dvd  = in_dividend;
      assign src_dvs  = in_divisor;
      assign src_rem  = '0;
      assign src_quo  = '0;
      assign src_side = in_side;
    end else begin : g_next
      assign src_vld  = vld_r[k-1];
      assign src_dvd  = dvd_r[k-1];
      assign src_dvs  = dvs_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_quo  = quo_r[k-1];
      assign src_side = side_r[k-1];
    end

    // Shift in the next dividend bit, subtract when it fits
    assign trial = {src_rem, src_dvd[DIVIDEND_W-1-k]};
    assign diff  = trial - {1'b0, src_dvs};
    assign ge    = trial >= {1'b0, src_dvs};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k]  <= DIVIDEND_W'({src_quo, ge});
        side_r[k] <= src_side;
      end
    end

    if (k < STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          dvd_r[k] <= src_dvd;
          dvs_r[k] <= src_dvs;
          rem_r[k] <= ge ? DIVISOR_W'(diff) : DIVISOR_W'(trial);
        end
      end
    end
  end

  assign out_vld  = vld_r[STAGES-1];
  assign out_quot = quo_r[STAGES-1];
  assign out_side = side_r[STAGES-1];

endmodule

// ===== hdl/hacr_back.sv =====
// Back end: CTS formula pipeline (N divide, clock multiply, x10, rate divide) and result register.
// Depends on hacr_pkg and hacr_div.
module hacr_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hacr_pkg::hacr_cfg_t          cfg,
  input  logic                         job_vld,
  input  hacr_pkg::hacr_job_t          job,
  output logic                         job_rdy,
  output logic                         out_vld,
  output logic [hacr_pkg::N_W-1:0]     out_n,
  output logic [hacr_pkg::CTS_W-1:0]   out_cts,
  output logic                         out_hit,
  input  logic                         out_rdy
);

  localparam int JOB_W = $bits(hacr_pkg::hacr_job_t);
  localparam int RES_W = $bits(hacr_pkg::hacr_res_t);

  logic                              en;
  logic [hacr_pkg::NDIV_W-1:0]       n_div;

  logic                              d1_vld;
  logic [hacr_pkg::N_W-1:0]          d1_quot;
  logic [JOB_W-1:0]                  d1_side_vec;
  hacr_pkg::hacr_job_t               d1_job;

  logic                              m1_vld_r;
  logic [hacr_pkg::CTS_W-1:0]        m1_prod_r;
  logic [hacr_pkg::RATE_Q_W-1:0]     m1_q_r;
  hacr_pkg::hacr_res_t               m1_res_r;

  logic                              m2_vld_r;
  logic [hacr_pkg::CTS_W-1:0]        m2_prod_r;
  logic [hacr_pkg::RATE_Q_W-1:0]     m2_q_r;
  hacr_pkg::hacr_res_t               m2_res_r;

  logic                              d2_vld;
  logic [hacr_pkg::CTS_W-1:0]        d2_quot;
  logic [RES_W-1:0]                  d2_side_vec;
  hacr_pkg::hacr_res_t               d2_res;

  logic                              out_vld_r;
  logic [hacr_pkg::N_W-1:0]          out_n_r;
  logic [hacr_pkg::CTS_W-1:0]        out_cts_r;
  logic                              out_hit_r;

  // Whole pipeline moves together; hold everything while a result waits
  assign en      = !out_vld_r || out_rdy;
  assign job_rdy = en;
  assign n_div   = (cfg.n_divisor == '0) ? hacr_pkg::NDIV_W'(1) : cfg.n_divisor;

  hacr_div #(
    .DIVIDEND_W (hacr_pkg::N_W),
    .DIVISOR_W  (hacr_pkg::NDIV_W),
    .SIDE_W     (JOB_W)
  ) u_ndiv (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (job_vld),
    .in_dividend (job.n),
    .in_divisor  (n_div),
    .in_side     (job),
    .out_vld     (d1_vld),
    .out_quot    (d1_quot),
    .out_side    (d1_side_vec)
  );

  assign d1_job = hacr_pkg::hacr_job_t'(d1_side_vec);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= d1_vld;
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_prod_r          <= hacr_pkg::CTS_W'((hacr_pkg::N_W + hacr_pkg::CLK_W)'(d1_quot) *
                                             (hacr_pkg::N_W + hacr_pkg::CLK_W)'(d1_job.clock));
      m1_q_r             <= d1_job.rate_q;
      m1_res_r.n           <= d1_job.n;
      m1_res_r.cts_base    <= d1_job.cts_base;
      m1_res_r.hit         <= d1_job.hit;
      m1_res_r.use_formula <= d1_job.use_formula;
      // times ten as 8x + 2x, wrapping at 32 bits
      m2_prod_r <= {m1_prod_r[hacr_pkg::CTS_W-4:0], 3'b000} +
                   {m1_prod_r[hacr_pkg::CTS_W-2:0], 1'b0};
      m2_q_r    <= m1_q_r;
      m2_res_r  <= m1_res_r;
    end
  end

  hacr_div #(
    .DIVIDEND_W (hacr_pkg::CTS_W),
    .DIVISOR_W  (hacr_pkg::RATE_Q_W),
    .SIDE_W     (RES_W)
  ) u_ratediv (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (m2_vld_r),
    .in_dividend (m2_prod_r),
    .in_divisor  (m2_q_r),
    .in_side     (m2_res_r),
    .out_vld     (d2_vld),
    .out_quot    (d2_quot),
    .out_side    (d2_side_vec)
  );

  assign d2_res = hacr_pkg::hacr_res_t'(d2_side_vec);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en && d2_vld) begin
      out_n_r   <= d2_res.n;
      out_cts_r <= d2_res.use_formula ? d2_quot : d2_res.cts_base;
      out_hit_r <= d2_res.hit;
    end
  end

  assign out_vld = out_vld_r;
  assign out_n   = out_n_r;
  assign out_cts = out_cts_r;
  assign out_hit = out_hit_r;

endmodule

// ===== hdl/hdmi_audio_n_cts_select.sv =====
// Top level of the HDMI audio clock regeneration N/CTS selector.
// Depends on hacr_pkg, hacr_if, hacr_front, hacr_fifo, hacr_div and hacr_back.
//
// Takes one query (sample rate in Hz, TMDS clock in kHz) per cycle while ready is high
// and returns one result (N, CTS, table hit) per query, in order. Throughput is one
// beat per cycle while the result side does not stall. An accepted query passes the
// ROM match register, the four-entry job queue, 20 stages of the N divider, two
// multiply stages, 32 stages of the rate divider and the result register; the
// dividers produce one quotient bit per stage. When the result side stalls,
// the back pipeline holds and the front keeps taking queries until the queue fills.
// Configuration writes take effect at once and belong in idle periods.
module hdmi_audio_n_cts_select #(
  parameter int TABLE_ENTRIES = 45
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [hacr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hacr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  hacr_in_if.sink                            in_chan,
  hacr_out_if.source                         out_chan
);

  hacr_pkg::hacr_cfg_t   cfg_r;

  logic                  front_job_vld;
  hacr_pkg::hacr_job_t   front_job;
  logic                  front_job_rdy;
  logic                  q_job_vld;
  hacr_pkg::hacr_job_t   q_job;
  logic                  q_job_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clock_tol  <= hacr_pkg::RST_CLOCK_TOL;
      cfg_r.fallback_n <= hacr_pkg::RST_FALLBACK_N;
      cfg_r.n_divisor  <= hacr_pkg::RST_N_DIVISOR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hacr_pkg::CFG_CLOCK_TOL: begin
          cfg_r.clock_tol <= cfg_wdata[hacr_pkg::TOL_W-1:0];
        end
        hacr_pkg::CFG_FALLBACK_N: begin
          cfg_r.fallback_n <= cfg_wdata[hacr_pkg::N_W-1:0];
        end
        hacr_pkg::CFG_N_DIVISOR: begin
          cfg_r.n_divisor <= cfg_wdata[hacr_pkg::NDIV_W-1:0];
        end
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  hacr_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_vld   (in_chan.valid),
    .in_rate  (in_chan.sample_rate_hz),
    .in_clock (in_chan.tmds_clock_khz),
    .in_rdy   (in_chan.ready),
    .job_vld  (front_job_vld),
    .job      (front_job),
    .job_rdy  (front_job_rdy)
  );

  hacr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_vld (front_job_vld),
    .push_job (front_job),
    .push_rdy (front_job_rdy),
    .pop_vld  (q_job_vld),
    .pop_job  (q_job),
    .pop_rdy  (q_job_rdy)
  );

  hacr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .job_vld (q_job_vld),
    .job     (q_job),
    .job_rdy (q_job_rdy),
    .out_vld (out_chan.valid),
    .out_n   (out_chan.n_value),
    .out_cts (out_chan.cts_value),
    .out_hit (out_chan.table_hit),
    .out_rdy (out_chan.ready)
  );

endmodule
